// ===== hdl/lvl_ramp_pkg.sv =====
// Shared types and constants of the level transition ramp.
package lvl_ramp_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_MIN_LEVEL   = 2'd0;
	localparam logic [1:0] REG_MAX_LEVEL   = 2'd1;
	localparam logic [1:0] REG_WRAP_ENABLE = 2'd2;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	localparam logic [15:0] FOREVER_TICKS = 16'hFFFF;
	localparam logic [16:0] ROUND_UP      = 17'd127;
	localparam logic [15:0] ONE_LEVEL     = 16'h0100;

	localparam logic [7:0] MIN_LEVEL_RST = 8'd1;
	localparam logic [7:0] MAX_LEVEL_RST = 8'd254;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic [15:0] load_ticks;
		logic [16:0] load_step;
		logic [15:0] load_fine;
	} in_word_t;

	typedef struct packed {
		logic        moving;
		logic [15:0] ticks_left;
		logic [15:0] fine_out;
		logic [7:0]  current_level;
	} out_word_t;

endpackage

// ===== hdl/level_transition_ramp.sv =====
// Level transition ramp: 8.8 fixed-point light level stepper with APB configuration.
// Each accepted word updates the registered ramp state, which drives the result word.
// Throughput: one word per cycle while the result side takes words; the combinational
// add, bound test and select of the ramp state set this figure, and a waiting result is replaced as it is taken.
// Reset: arst_n clears the ramp state and the output valid at once and loads the
// bound registers with min 1, max 254 and clamping.
module level_transition_ramp (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [lvl_ramp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lvl_ramp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lvl_ramp_pkg::APB_DATA_W-1:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// load_fine[15:0], load_step[32:16], load_ticks[48:33], zero[55:49]
	input  logic [lvl_ramp_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// kind[0]
	input  logic        s_axis_tuser,
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// current_level[7:0], fine_out[23:8], ticks_left[39:24], moving[40], zero[47:41]
	output logic [lvl_ramp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic [7:0]  min_q;
	logic [7:0]  max_q;
	logic        wrap_q;
	logic [15:0] fine_q;
	logic [16:0] step_q;
	logic [15:0] ticks_q;
	logic [7:0]  level_q;
	logic        out_valid_q;

	logic                   cfg_wr;
	logic                   in_acc;
	lvl_ramp_pkg::in_word_t in_word;
	lvl_ramp_pkg::out_word_t out_word;

	logic [17:0] sum;
	logic        step_pos;
	logic        step_neg;
	logic        below_min;
	logic        over_up;
	logic        over_dn;
	logic [15:0] lo16;
	logic [15:0] hi16;
	logic [15:0] wrap_up;
	logic [15:0] wrap_dn;
	logic [15:0] fine_upd;
	logic [16:0] rnd;
	logic [7:0]  level_upd;
	logic [15:0] fine_n;
	logic [16:0] step_n;
	logic [15:0] ticks_n;
	logic [7:0]  level_n;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			lvl_ramp_pkg::REG_MIN_LEVEL:   prdata[7:0] = min_q;
			lvl_ramp_pkg::REG_MAX_LEVEL:   prdata[7:0] = max_q;
			lvl_ramp_pkg::REG_WRAP_ENABLE: prdata[0]   = wrap_q;
			default:                       prdata      = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= lvl_ramp_pkg::MIN_LEVEL_RST;
			max_q  <= lvl_ramp_pkg::MAX_LEVEL_RST;
			wrap_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lvl_ramp_pkg::REG_MIN_LEVEL:   min_q  <= pwdata[7:0];
				lvl_ramp_pkg::REG_MAX_LEVEL:   max_q  <= pwdata[7:0];
				lvl_ramp_pkg::REG_WRAP_ENABLE: wrap_q <= pwdata[0];
				default:                       ;
			endcase
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_word       = lvl_ramp_pkg::in_word_t'(s_axis_tdata[48:0]);

	// tick and load update
	always_comb begin
		sum       = {2'b00, fine_q} + {step_q[16], step_q};
		step_neg  = step_q[16];
		step_pos  = !step_q[16] && (step_q != '0);
		below_min = sum[17] ? ((min_q != '0) || (sum[17:8] != '1) || (sum[7:0] == '0))
		                    : (sum[17:8] < {2'b00, min_q});
		over_up   = step_pos && (sum[17:8] > {2'b00, max_q});
		over_dn   = step_neg && below_min;
		lo16      = {min_q, 8'h00};
		hi16      = {max_q, 8'h00};
		wrap_up   = sum[15:0] + lo16 - hi16 - lvl_ramp_pkg::ONE_LEVEL;
		wrap_dn   = sum[15:0] + hi16 - lo16 + lvl_ramp_pkg::ONE_LEVEL;
		if (over_up) begin
			fine_upd = wrap_q ? wrap_up : hi16;
		end else if (over_dn) begin
			fine_upd = wrap_q ? wrap_dn : lo16;
		end else begin
			fine_upd = sum[15:0];
		end
		rnd       = {1'b0, fine_upd} + lvl_ramp_pkg::ROUND_UP;
		level_upd = step_pos ? rnd[15:8] : fine_upd[15:8];

		if (s_axis_tuser == lvl_ramp_pkg::KIND_LOAD) begin
			fine_n  = in_word.load_fine;
			step_n  = in_word.load_step;
			ticks_n = in_word.load_ticks;
			level_n = level_q;
		end else if (ticks_q == '0) begin
			fine_n  = {level_upd, 8'h00};
			step_n  = '0;
			ticks_n = ticks_q;
			level_n = level_upd;
		end else begin
			fine_n  = fine_upd;
			step_n  = step_q;
			ticks_n = (ticks_q == lvl_ramp_pkg::FOREVER_TICKS) ? ticks_q : ticks_q - 16'd1;
			level_n = level_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q      <= '0;
			step_q      <= '0;
			ticks_q     <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				fine_q  <= fine_n;
				step_q  <= step_n;
				ticks_q <= ticks_n;
				level_q <= level_n;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_word.current_level = level_q;
		out_word.fine_out      = fine_q;
		out_word.ticks_left    = ticks_q;
		out_word.moving        = (step_q != '0);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_word};

`ifndef SYNTH
	a_acc_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> m_axis_tvalid)
		else $error("accepted word produced no result");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser == lvl_ramp_pkg::KIND_TICK && ticks_q != '0
		 && ticks_q != lvl_ramp_pkg::FOREVER_TICKS)
		|=> ticks_q == $past(ticks_q) - 16'd1)
		else $error("tick count did not advance");

	a_snap_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser == lvl_ramp_pkg::KIND_TICK && ticks_q == '0)
		|=> (step_q == '0) && (fine_q == {level_q, 8'h00}))
		else $error("exhausted ramp did not snap to level");

	a_load_keeps_level: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser == lvl_ramp_pkg::KIND_LOAD) |=> $stable(level_q))
		else $error("load changed the level");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the level transition ramp with its bound registers.
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LEVEL_SCALE = 256;
	localparam int RAMP_ITEMS  = 162;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic                   kind;
		lvl_ramp_pkg::in_word_t w;
	} ramp_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [lvl_ramp_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [lvl_ramp_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [lvl_ramp_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// load_fine[15:0], load_step[32:16], load_ticks[48:33], zero[55:49]
	logic [lvl_ramp_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	// kind[0]
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// current_level[7:0], fine_out[23:8], ticks_left[39:24], moving[40], zero[47:41]
	logic [lvl_ramp_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	level_transition_ramp i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// ramp model state and bound registers
	logic [15:0] pos_q = '0;
	logic signed [17:0] rate_q = '0;
	logic [15:0] ticks_q = '0;
	logic [7:0] level_q = '0;
	logic [7:0] cfg_min = lvl_ramp_pkg::MIN_LEVEL_RST;
	logic [7:0] cfg_max = lvl_ramp_pkg::MAX_LEVEL_RST;
	logic cfg_wrap = 1'b0;

	ramp_cmd_t ramp_cmds[$];
	lvl_ramp_pkg::out_word_t levels_due[$];
	ramp_cmd_t next_cmd;
	ramp_cmd_t taken_cmd;
	lvl_ramp_pkg::out_word_t got_word;
	lvl_ramp_pkg::out_word_t want_word;
	bit word_taken = 1'b0;
	bit steady = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int cycle_cnt = 0;
	int fail_cnt = 0;
	int words_queued = 0;
	int words_answered = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic lvl_ramp_pkg::out_word_t ramp_update(ramp_cmd_t c);
		int sum;
		int quot;
		int lo;
		int hi;
		logic [15:0] nxt;
		lvl_ramp_pkg::out_word_t r;
		if (c.kind == lvl_ramp_pkg::KIND_LOAD) begin
			pos_q = c.w.load_fine;
			rate_q = {c.w.load_step[16], c.w.load_step};
			ticks_q = c.w.load_ticks;
		end else begin
			sum = int'(pos_q) + int'(rate_q);
			quot = sum / LEVEL_SCALE;
			lo = int'(cfg_min) * LEVEL_SCALE;
			hi = int'(cfg_max) * LEVEL_SCALE;
			if (rate_q > 0 && quot > int'(cfg_max)) begin
				nxt = cfg_wrap ? 16'(lo + (sum - hi) - LEVEL_SCALE) : 16'(hi);
			end else if (rate_q < 0 && quot < int'(cfg_min)) begin
				nxt = cfg_wrap ? 16'(hi - (lo - sum) + LEVEL_SCALE) : 16'(lo);
			end else begin
				nxt = 16'(sum);
			end
			if (rate_q > 0) begin
				level_q = 8'((int'(nxt) + 127) / LEVEL_SCALE);
			end else begin
				level_q = nxt[15:8];
			end
			if (ticks_q == 16'd0) begin
				pos_q = {level_q, 8'h00};
				rate_q = '0;
			end else begin
				pos_q = nxt;
				if (ticks_q != lvl_ramp_pkg::FOREVER_TICKS) begin
					ticks_q = ticks_q - 16'd1;
				end
			end
		end
		r.current_level = level_q;
		r.fine_out = pos_q;
		r.ticks_left = ticks_q;
		r.moving = (rate_q != 0);
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// sender
	always @(negedge clk) begin
		if (!s_axis_tvalid || word_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (ramp_cmds.size() != 0) begin
				next_cmd = ramp_cmds.pop_front();
				s_axis_tuser <= next_cmd.kind;
				s_axis_tdata <= {{(lvl_ramp_pkg::IN_DATA_W - $bits(lvl_ramp_pkg::in_word_t)){1'b0}},
					next_cmd.w};
				s_axis_tvalid <= 1'b1;
				gap_left <= idle_len();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left <= idle_len();
		end
	end

	// monitor: check result words, then predict for the word just taken
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_word = m_axis_tdata[$bits(lvl_ramp_pkg::out_word_t)-1:0];
				if (levels_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX) begin
						$display("unexpected result: level %0d fine %h ticks %h moving %b",
							got_word.current_level, got_word.fine_out,
							got_word.ticks_left, got_word.moving);
					end
				end else begin
					want_word = levels_due.pop_front();
					words_answered++;
					if (got_word.current_level !== want_word.current_level ||
						got_word.fine_out !== want_word.fine_out ||
						got_word.ticks_left !== want_word.ticks_left ||
						got_word.moving !== want_word.moving) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX) begin
							$display("mismatch at %0d (exp/got): level %0d/%0d fine %h/%h %s",
								cycle_cnt, want_word.current_level, got_word.current_level,
								want_word.fine_out, got_word.fine_out,
								$sformatf("ticks %h/%h moving %b/%b",
									want_word.ticks_left, got_word.ticks_left,
									want_word.moving, got_word.moving));
						end
					end
				end
			end
			word_taken = s_axis_tvalid && s_axis_tready;
			if (word_taken) begin
				taken_cmd.kind = s_axis_tuser;
				taken_cmd.w = s_axis_tdata[$bits(lvl_ramp_pkg::in_word_t)-1:0];
				levels_due.push_back(ramp_update(taken_cmd));
			end
		end
	end

	task automatic push_load(int fine, int step, int ticks);
		ramp_cmd_t c;
		c.kind = lvl_ramp_pkg::KIND_LOAD;
		c.w.load_fine = 16'(fine);
		c.w.load_step = 17'(step);
		c.w.load_ticks = 16'(ticks);
		ramp_cmds.push_back(c);
		words_queued++;
	endtask

	task automatic push_tick(int n);
		ramp_cmd_t c;
		repeat (n) begin
			c.kind = lvl_ramp_pkg::KIND_TICK;
			c.w.load_fine = 16'($urandom);
			c.w.load_step = 17'($urandom);
			c.w.load_ticks = 16'($urandom);
			ramp_cmds.push_back(c);
			words_queued++;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (words_answered != words_queued);
		repeat (2) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			lvl_ramp_pkg::REG_MIN_LEVEL: cfg_min = val;
			lvl_ramp_pkg::REG_MAX_LEVEL: cfg_max = val;
			lvl_ramp_pkg::REG_WRAP_ENABLE: cfg_wrap = val[0];
			default: ;
		endcase
	endtask

	task automatic set_bounds(int lo, int hi, int wrap);
		wait_drained();
		reg_write(lvl_ramp_pkg::REG_MIN_LEVEL, 8'(lo));
		reg_write(lvl_ramp_pkg::REG_MAX_LEVEL, 8'(hi));
		reg_write(lvl_ramp_pkg::REG_WRAP_ENABLE, 8'(wrap));
		@(posedge clk);
	endtask

	function automatic int pick_step();
		int mag;
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2, 3: mag = $urandom_range(1, 64);
			4, 5, 6, 7: mag = $urandom_range(65, 2048);
			default: mag = $urandom_range(2049, 65535);
		endcase
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	function automatic int pick_fine();
		case ($urandom_range(0, 3))
			0: return {cfg_min, 8'($urandom)};
			1: return {cfg_max, 8'($urandom)};
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_ticks();
		case ($urandom_range(0, 9))
			0: return int'(lvl_ramp_pkg::FOREVER_TICKS);
			1: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	task automatic fill_ramp(int quota, bit hold_midway);
		int made;
		int n;
		int k;
		made = 0;
		while (made < quota) begin
			if (hold_midway && made >= quota / 2) begin
				hold_midway = 1'b0;
				wait_drained();
				@(posedge clk);
			end
			k = $urandom_range(0, 19);
			if (k == 0) begin
				push_tick(1);
				made++;
			end else if (k == 1) begin
				push_load($urandom_range(0, 65535), $urandom_range(0, 131070) - 65535,
					$urandom_range(0, 65535));
				made++;
			end else begin
				n = $urandom_range(1, 24);
				push_load(pick_fine(), pick_step(), pick_ticks());
				push_tick(n);
				made += n + 1;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset bounds: clamp between 1 and 254
		push_tick(1);
		push_load(0, 65535, int'(lvl_ramp_pkg::FOREVER_TICKS));
		push_tick(2);
		push_load(16'hFFFF, -65535, 3);
		push_tick(1);
		push_load(16'h0100, -16'h0110, 1);
		push_tick(3);
		push_load(16'h1234, 16'h0080, 2);
		push_tick(2);
		push_load(16'hFFFF, 65535, int'(lvl_ramp_pkg::FOREVER_TICKS));
		push_tick(1);
		push_load(0, 0, 0);

		// full range with wrap: level rounds up to 256 and drops to 0
		set_bounds(0, 255, 1);
		push_load(16'hFF70, 16'h0020, 6);
		push_tick(5);
		push_load(16'h0005, -16'h0010, 2);
		push_tick(1);
		push_load(16'h0010, -16'h0300, 0);
		push_tick(1);
		push_load(16'h0000, -16'h0100, 3);
		push_tick(1);
		fill_ramp(RAMP_ITEMS, 1'b0);

		for (int p = 2; p < 11; p++) begin
			case (p)
				2: set_bounds(0, 255, 0);
				3: set_bounds(255, 0, 1);
				4: set_bounds(255, 255, 0);
				5: set_bounds(0, 0, 1);
				default: set_bounds($urandom_range(0, 120), $urandom_range(130, 255),
					$urandom_range(0, 1));
			endcase
			steady = (p % 4 == 1);
			fill_ramp(RAMP_ITEMS, p == 6);
		end

		wait_drained();
		repeat (5) @(negedge clk);
		if (fail_cnt == 0 && levels_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
